### sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes, widths and types for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   // default store depth
   localparam int DEPTH_DEFAULT = 8;

   // field widths
   localparam int ACTION_W = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   // packed bus widths, padded to whole bytes
   localparam int REQ_FIELDS_W = ACTION_W + WORD_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 2 * WORD_W + 2;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request, start store reads
      logic commit;    // apply the action and load the response register
   } cdq_cmd_type;

endpackage : cdq_pkg

`default_nettype wire

### sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Request sequencer: accept, read the store ends, commit into the response slot.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
   import cdq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output cdq_cmd_type      cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic commit;

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   // response slot is free, or its occupant leaves this cycle
   assign commit      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.commit  = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_EXEC))
      else $error("capture did not move to execute");

   a_commit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed response not presented");

   a_no_capture_and_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && commit))
      else $error("capture and commit in the same cycle");

endmodule : cdq_ctrl

`default_nettype wire

### sv/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque store, end indices, fill count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dpath
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cdq_cmd_type             cmd,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic       [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
   localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);

   logic [WORD_W-1:0]   mem [DEPTH];

   logic [ACTION_W-1:0] action_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [WORD_W-1:0]   rd_front_ff, rd_back_ff;
   logic [IW-1:0]       front_ff, front_in;
   logic [IW-1:0]       back_ff, back_in;
   logic [OW-1:0]       occ_ff, occ_in;
   logic [RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [IW-1:0]       front_dec, back_inc, front_inc, back_dec;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   data, back_word;
   logic                is_empty_now, is_full_now;

   assign is_empty_now = (occ_ff == '0);
   assign is_full_now  = (occ_ff == OCC_FULL);
   assign front_dec = (front_ff == '0) ? IDX_LAST : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_LAST) ? '0 : front_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? IDX_LAST : back_ff - 1'b1;
   assign back_inc  = (back_ff == IDX_LAST) ? '0 : back_ff + 1'b1;

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      occ_in    = occ_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      status    = ST_OK;
      data      = '0;
      back_word = '0;
      unique case (action_ff)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (is_full_now) begin
               status = ST_FULL;
            end else if (is_empty_now) begin
               front_in = '0;
               back_in  = '0;
               wr_en    = 1'b1;
               wr_addr  = '0;
               occ_in   = OW'(1);
            end else if (action_ff == ACT_PUSH_FRONT) begin
               front_in = front_dec;
               wr_en    = 1'b1;
               wr_addr  = front_dec;
               occ_in   = occ_ff + 1'b1;
            end else begin
               back_in  = back_inc;
               wr_en    = 1'b1;
               wr_addr  = back_inc;
               occ_in   = occ_ff + 1'b1;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (is_empty_now) begin
               status = ST_EMPTY;
            end else begin
               data = (action_ff == ACT_POP_FRONT) ? rd_front_ff : rd_back_ff;
               if (occ_ff == OW'(1)) begin
                  // last word out: back to the home position
                  front_in = '0;
                  back_in  = '0;
                  occ_in   = '0;
               end else begin
                  if (action_ff == ACT_POP_FRONT) front_in = front_inc;
                  else                            back_in  = back_dec;
                  occ_in = occ_ff - 1'b1;
               end
            end
         end
         ACT_PEEK: begin
            if (is_empty_now) begin
               status = ST_EMPTY;
            end else begin
               data      = rd_front_ff;
               back_word = rd_back_ff;
            end
         end
         default: ;  // unknown action: report fill only
      endcase
   end

   // fields from bit 0 up: status, front_or_popped, back_value, is_full, is_empty
   assign rsp_in = RSP_TDATA_W'({(occ_in == '0), (occ_in == OCC_FULL),
                                 back_word, data, status});
   assign rsp_tdata = rsp_ff;

   // store: one write port, two registered reads at the current ends
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) mem[wr_addr] <= word_ff;
      rd_front_ff <= mem[front_ff];
      rd_back_ff  <= mem[back_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_tdata[ACTION_W-1:0];
         word_ff   <= req_tdata[ACTION_W +: WORD_W];
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         occ_ff   <= '0;
      end else if (cmd.commit) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         occ_ff   <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("fill count beyond depth");

   a_single_home: assert property (@(posedge clock) disable iff (reset)
      (occ_ff <= OW'(1)) |-> (front_ff == back_ff))
      else $error("ends differ with at most one word held");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_full_now) |-> !wr_en)
      else $error("store written while full");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(occ_ff) && $stable(front_ff) && $stable(back_ff))
      else $error("deque state moved without a commit");

endmodule : cdq_dpath

`default_nettype wire

### sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Each request carries one action: push front, push back, pop front, pop
// back, or peek at both ends. Every request yields exactly one response with
// a status (ok, full, empty), the popped or front word, the back word on a
// peek, and full/empty flags valid after the action. Refused actions and
// unknown action codes change nothing. Each request first has both ends of
// the store read into registers, then the action is applied and the
// response register loaded. A new request is accepted only once the
// previous one has been committed. The response register lets the
// next request be accepted while the previous response waits. The store
// needs no clearing after reset; words are only read once pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT   // words held
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: [2:0] action, [34:3] push_value, [39:35] zero
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // response: [1:0] status, [33:2] front_or_popped, [65:34] back_value,
   //           [66] is_full, [67] is_empty, [71:68] zero
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   cdq_cmd_type cmd;

   // sequencer: handshakes and command strobes
   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // store, indices, fill count, response register
   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule : circular_deque

`default_nettype wire
